[rtl/core/pap_pkg.sv]
`timescale 1ns / 1ps

package pap_pkg;

    // Window and sample sizing
    localparam int WINDOW_LENGTH = 10;
    localparam int SAMPLE_BITS   = 12;
    localparam int POS_W         = $clog2(WINDOW_LENGTH);
    localparam int SUM_W         = SAMPLE_BITS + $clog2(WINDOW_LENGTH);

    // Exact divide by the window length: floor(x * RECIP_MULT >> RECIP_SHIFT)
    localparam int RECIP_SHIFT   = SUM_W + $clog2(WINDOW_LENGTH);
    localparam int RECIP_W       = SUM_W + 1;
    localparam longint RECIP_MULT =
        ((64'd1 << RECIP_SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
    localparam int MEAN_PROD_W   = SUM_W + RECIP_W;

    // Register file
    localparam int TIMER_W   = 10;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 3;
    localparam int BAT_W     = 12;
    localparam int PCT_W     = 7;
    localparam int CMP_W     = ((SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W) + 1;

    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    localparam logic [TIMER_W-1:0] RST_SAMPLE_INTERVAL   = 10'd10;
    localparam logic [TIMER_W-1:0] RST_APPROACH_INTERVAL = 10'd100;
    localparam logic [CFG_W-1:0]   RST_APPROACH_MARGIN   = 12'd5;
    localparam logic [TIMER_W-1:0] RST_NEAR_HALF_PERIOD  = 10'd125;
    localparam logic [TIMER_W-1:0] RST_FAR_HALF_PERIOD   = 10'd250;
    localparam logic [CFG_W-1:0]   RST_FRONT_LOW_LIMIT   = 12'd930;
    localparam logic [CFG_W-1:0]   RST_FRONT_HIGH_LIMIT  = 12'd3970;

    // Bargraph scaling, Q16
    localparam int PCT_MAX      = 100;
    localparam int Q_SHIFT      = 16;
    localparam int BAT_PROD_W   = 14 + BAT_W;
    localparam int FRONT_PROD_W = (SAMPLE_BITS + 12 > 22) ? SAMPLE_BITS + 12 : 22;
    localparam logic [BAT_W-1:0]        BAT_LOW      = 12'd3102;
    localparam logic [BAT_W-1:0]        BAT_HIGH     = 12'd3723;
    localparam logic [BAT_PROD_W-1:0]   BAT_GAIN     = BAT_PROD_W'(10562);
    localparam logic [BAT_PROD_W-1:0]   BAT_OFFSET   = BAT_PROD_W'(32768000);
    localparam logic [FRONT_PROD_W-1:0] FRONT_GAIN   = FRONT_PROD_W'(2163);
    localparam logic [FRONT_PROD_W-1:0] FRONT_OFFSET = FRONT_PROD_W'(2011300);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_INTERVAL   = 3'd0,
        REG_APPROACH_INTERVAL = 3'd1,
        REG_APPROACH_MARGIN   = 3'd2,
        REG_NEAR_HALF_PERIOD  = 3'd3,
        REG_FAR_HALF_PERIOD   = 3'd4,
        REG_FRONT_LOW_LIMIT   = 3'd5,
        REG_FRONT_HIGH_LIMIT  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [TIMER_W-1:0] sample_interval;
        logic [TIMER_W-1:0] approach_interval;
        logic [CFG_W-1:0]   approach_margin;
        logic [TIMER_W-1:0] near_half_period;
        logic [TIMER_W-1:0] far_half_period;
        logic [CFG_W-1:0]   front_low_limit;
        logic [CFG_W-1:0]   front_high_limit;
    } cfg_t;

    // Item after the window stage
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [BAT_W-1:0] battery;
        logic             near_zone;
        logic             far_zone;
        logic             horn;
    } win_item_t;

    // Item after the detect stage
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] mean;
        logic                   approaching;
        logic                   beeper;
        logic [BAT_W-1:0]       battery;
    } det_item_t;

    typedef struct packed {
        logic [TIMER_W-1:0] count;
        logic               fire;
    } timer_t;

    // Saturating interval timer: fire and restart once the count reaches the interval
    function automatic timer_t timer_step(input logic [TIMER_W-1:0] count,
                                          input logic [TIMER_W-1:0] interval);
        timer_t             res;
        logic [TIMER_W-1:0] inc;
        inc = (count < TIMER_MAX) ? count + 1'b1 : count;
        if (inc >= interval) begin
            res.count = '0;
            res.fire  = 1'b1;
        end else begin
            res.count = inc;
            res.fire  = 1'b0;
        end
        return res;
    endfunction

endpackage

[rtl/core/pap_cfg.sv]
`timescale 1ns / 1ps

module pap_cfg
    import pap_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_interval   <= RST_SAMPLE_INTERVAL;
            cfg_reg.approach_interval <= RST_APPROACH_INTERVAL;
            cfg_reg.approach_margin   <= RST_APPROACH_MARGIN;
            cfg_reg.near_half_period  <= RST_NEAR_HALF_PERIOD;
            cfg_reg.far_half_period   <= RST_FAR_HALF_PERIOD;
            cfg_reg.front_low_limit   <= RST_FRONT_LOW_LIMIT;
            cfg_reg.front_high_limit  <= RST_FRONT_HIGH_LIMIT;
        end else if (cfg_write) begin
            case (reg_idx_t'(cfg_index))
                REG_SAMPLE_INTERVAL:   cfg_reg.sample_interval   <= cfg_wdata[TIMER_W-1:0];
                REG_APPROACH_INTERVAL: cfg_reg.approach_interval <= cfg_wdata[TIMER_W-1:0];
                REG_APPROACH_MARGIN:   cfg_reg.approach_margin   <= cfg_wdata;
                REG_NEAR_HALF_PERIOD:  cfg_reg.near_half_period  <= cfg_wdata[TIMER_W-1:0];
                REG_FAR_HALF_PERIOD:   cfg_reg.far_half_period   <= cfg_wdata[TIMER_W-1:0];
                REG_FRONT_LOW_LIMIT:   cfg_reg.front_low_limit   <= cfg_wdata;
                REG_FRONT_HIGH_LIMIT:  cfg_reg.front_high_limit  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/pap_window.sv]
`timescale 1ns / 1ps

module pap_window
    import pap_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  logic                   in_valid,
    input  logic [SAMPLE_BITS-1:0] in_front,
    input  logic [BAT_W-1:0]       in_battery,
    input  logic                   in_near,
    input  logic                   in_far,
    input  logic                   in_horn,
    input  logic [TIMER_W-1:0]     sample_interval,
    output logic                   win_valid,
    output win_item_t              win_item
);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] front;
        logic [BAT_W-1:0]       battery;
        logic                   near_zone;
        logic                   far_zone;
        logic                   horn;
    } in_item_t;

    logic                   in_valid_reg;
    in_item_t               in_item_reg;
    logic [SAMPLE_BITS-1:0] ring_reg [WINDOW_LENGTH];
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [TIMER_W-1:0]     elapsed_reg;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic                   win_valid_reg;
    win_item_t              win_item_reg;
    timer_t                 tm;
    logic                   work;
    logic                   store;

    assign work  = advance && in_valid_reg;
    assign tm    = timer_step(elapsed_reg, sample_interval);
    assign store = work && tm.fire;

    // Running sum: drop the entry being overwritten, add the new sample
    always_comb begin
        sum_next = sum_reg;
        pos_next = pos_reg;
        if (tm.fire) begin
            sum_next = sum_reg - SUM_W'(ring_reg[pos_reg]) + SUM_W'(in_item_reg.front);
            pos_next = (pos_reg == POS_W'(WINDOW_LENGTH - 1)) ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            win_valid_reg <= 1'b0;
            pos_reg       <= '0;
            elapsed_reg   <= '0;
            sum_reg       <= '0;
            for (int i = 0; i < WINDOW_LENGTH; i++) begin
                ring_reg[i] <= '0;
            end
        end else begin
            if (advance) begin
                in_valid_reg  <= in_valid;
                win_valid_reg <= in_valid_reg;
            end
            if (work) begin
                elapsed_reg <= tm.count;
                sum_reg     <= sum_next;
                pos_reg     <= pos_next;
            end
            if (store) begin
                ring_reg[pos_reg] <= in_item_reg.front;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            in_item_reg.front     <= in_front;
            in_item_reg.battery   <= in_battery;
            in_item_reg.near_zone <= in_near;
            in_item_reg.far_zone  <= in_far;
            in_item_reg.horn      <= in_horn;
            win_item_reg.sum       <= sum_next;
            win_item_reg.battery   <= in_item_reg.battery;
            win_item_reg.near_zone <= in_item_reg.near_zone;
            win_item_reg.far_zone  <= in_item_reg.far_zone;
            win_item_reg.horn      <= in_item_reg.horn;
        end
    end

    assign win_valid = win_valid_reg;
    assign win_item  = win_item_reg;

endmodule

[rtl/core/pap_detect.sv]
`timescale 1ns / 1ps

module pap_detect
    import pap_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  logic      win_valid,
    input  win_item_t win_item,
    input  cfg_t      cfg,
    output logic      det_valid,
    output det_item_t det_item
);

    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_MULT);

    logic [MEAN_PROD_W-1:0] mean_prod;
    logic [SAMPLE_BITS-1:0] mean;
    logic [SAMPLE_BITS-1:0] prev_avg_reg;
    logic [TIMER_W-1:0]     appr_elapsed_reg;
    logic [TIMER_W-1:0]     beep_elapsed_reg, beep_elapsed_next;
    logic                   beeper_reg, beeper_next;
    logic                   approaching;
    logic                   det_valid_reg;
    det_item_t              det_item_reg;
    timer_t                 appr_tm;
    timer_t                 beep_tm;
    logic [TIMER_W-1:0]     half;
    logic                   work;
    logic                   rear;
    logic                   ahead;

    assign work      = advance && win_valid;
    assign mean_prod = MEAN_PROD_W'(win_item.sum) * MEAN_PROD_W'(RECIP);
    assign mean      = mean_prod[RECIP_SHIFT +: SAMPLE_BITS];

    assign appr_tm     = timer_step(appr_elapsed_reg, cfg.approach_interval);
    assign approaching = appr_tm.fire &&
        (CMP_W'(mean) > CMP_W'(prev_avg_reg) + CMP_W'(cfg.approach_margin));

    assign half    = win_item.near_zone ? cfg.near_half_period : cfg.far_half_period;
    assign beep_tm = timer_step(beep_elapsed_reg, half);
    assign rear    = !win_item.far_zone;
    assign ahead   = (CMP_W'(mean) >= CMP_W'(cfg.front_low_limit)) && approaching;

    // Horn holds the beeper on; its timer keeps counting but never fires
    always_comb begin
        beep_elapsed_next = beep_elapsed_reg;
        beeper_next       = beeper_reg;
        if (win_item.horn) begin
            if (beep_elapsed_reg < TIMER_MAX) begin
                beep_elapsed_next = beep_elapsed_reg + 1'b1;
            end
            beeper_next = 1'b1;
        end else begin
            beep_elapsed_next = beep_tm.count;
            if (beep_tm.fire) begin
                beeper_next = (rear || ahead) ? !beeper_reg : 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            det_valid_reg    <= 1'b0;
            prev_avg_reg     <= '0;
            appr_elapsed_reg <= '0;
            beep_elapsed_reg <= '0;
            beeper_reg       <= 1'b0;
        end else begin
            if (advance) begin
                det_valid_reg <= win_valid;
            end
            if (work) begin
                appr_elapsed_reg <= appr_tm.count;
                if (appr_tm.fire) begin
                    prev_avg_reg <= mean;
                end
                beep_elapsed_reg <= beep_elapsed_next;
                beeper_reg       <= beeper_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            det_item_reg.mean        <= mean;
            det_item_reg.approaching <= approaching;
            det_item_reg.beeper      <= beeper_next;
            det_item_reg.battery     <= win_item.battery;
        end
    end

    assign det_valid = det_valid_reg;
    assign det_item  = det_item_reg;

endmodule

[rtl/core/pap_bar.sv]
`timescale 1ns / 1ps

module pap_bar
    import pap_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  logic                   det_valid,
    input  det_item_t              det_item,
    input  cfg_t                   cfg,
    output logic                   out_valid,
    output logic [SAMPLE_BITS-1:0] out_average,
    output logic                   out_approaching,
    output logic                   out_beeper,
    output logic [PCT_W-1:0]       out_percent
);

    localparam int FRONT_Q_W = FRONT_PROD_W - Q_SHIFT;
    localparam int BAT_Q_W   = BAT_PROD_W - Q_SHIFT;

    logic [FRONT_PROD_W-1:0] front_prod, front_diff;
    logic [BAT_PROD_W-1:0]   bat_prod, bat_diff;
    logic [FRONT_Q_W-1:0]    front_q;
    logic [BAT_Q_W-1:0]      bat_q;
    logic [PCT_W-1:0]        front_pct, bat_pct, pct;

    logic                   valid_reg;
    logic [SAMPLE_BITS-1:0] average_reg;
    logic                   approaching_reg;
    logic                   beeper_reg;
    logic [PCT_W-1:0]       percent_reg;

    assign front_prod = FRONT_GAIN * FRONT_PROD_W'(det_item.mean);
    assign front_diff = front_prod - FRONT_OFFSET;
    assign front_q    = front_diff[FRONT_PROD_W-1:Q_SHIFT];

    assign bat_prod = BAT_GAIN * BAT_PROD_W'(det_item.battery);
    assign bat_diff = bat_prod - BAT_OFFSET;
    assign bat_q    = bat_diff[BAT_PROD_W-1:Q_SHIFT];

    always_comb begin
        // front proximity: negative gives empty, clamp at full
        if (front_prod < FRONT_OFFSET) begin
            front_pct = '0;
        end else if (front_q > FRONT_Q_W'(PCT_MAX)) begin
            front_pct = PCT_W'(PCT_MAX);
        end else begin
            front_pct = front_q[PCT_W-1:0];
        end

        // battery: between the limits the product stays above the offset
        if (det_item.battery <= BAT_LOW) begin
            bat_pct = '0;
        end else if (det_item.battery >= BAT_HIGH) begin
            bat_pct = PCT_W'(PCT_MAX);
        end else if (bat_q > BAT_Q_W'(PCT_MAX)) begin
            bat_pct = PCT_W'(PCT_MAX);
        end else begin
            bat_pct = bat_q[PCT_W-1:0];
        end

        // low limit wins when the limits cross
        if (CMP_W'(det_item.mean) <= CMP_W'(cfg.front_low_limit)) begin
            pct = '0;
        end else if (CMP_W'(det_item.mean) > CMP_W'(cfg.front_high_limit)) begin
            pct = bat_pct;
        end else begin
            pct = front_pct;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= det_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            average_reg     <= det_item.mean;
            approaching_reg <= det_item.approaching;
            beeper_reg      <= det_item.beeper;
            percent_reg     <= pct;
        end
    end

    assign out_valid       = valid_reg;
    assign out_average     = average_reg;
    assign out_approaching = approaching_reg;
    assign out_beeper      = beeper_reg;
    assign out_percent     = percent_reg;

endmodule

[rtl/core/parking_assist_proximity.sv]
`timescale 1ns / 1ps
// Parking-assist proximity: one input item per millisecond tick carries the
// front distance and battery converter readings, the rear zone flags and the
// horn button; one result item per tick gives the ring average of the front
// readings, the approach flag, the beeper level and the bargraph percent.
// Input channel s_valid/s_ready, result channel m_valid/m_ready. Registers
// are written through cfg_write/cfg_index/cfg_wdata; the user must write
// them only while no item is in flight, which the block does not enforce.
// Four register stages: input register, window sum, detection (average,
// approach, beeper), bargraph and result register. One item per cycle is
// sustained while m_ready is high, set by the single pipeline enable.
// When the receiver stalls, the whole pipeline holds and s_ready drops once
// the result register is full; nothing is lost or repeated.
// Reset is synchronous: it clears the averaging ring, all timers, the
// previous average and the beeper, and loads the register defaults.

module parking_assist_proximity
    import pap_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_front_sample,
    input  logic [BAT_W-1:0]       s_battery_sample,
    input  logic                   s_near_zone,
    input  logic                   s_far_zone,
    input  logic                   s_horn_pressed,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SAMPLE_BITS-1:0] m_front_average,
    output logic                   m_approaching,
    output logic                   m_beeper_on,
    output logic [PCT_W-1:0]       m_bar_percent
);

    cfg_t      cfg;
    logic      advance;
    logic      win_valid;
    win_item_t win_item;
    logic      det_valid;
    det_item_t det_item;

    // advance every stage whenever the result register is free or being taken
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    pap_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pap_window u_window (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .in_valid        (s_valid),
        .in_front        (s_front_sample),
        .in_battery      (s_battery_sample),
        .in_near         (s_near_zone),
        .in_far          (s_far_zone),
        .in_horn         (s_horn_pressed),
        .sample_interval (cfg.sample_interval),
        .win_valid       (win_valid),
        .win_item        (win_item)
    );

    pap_detect u_detect (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .win_valid (win_valid),
        .win_item  (win_item),
        .cfg       (cfg),
        .det_valid (det_valid),
        .det_item  (det_item)
    );

    pap_bar u_bar (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .det_valid       (det_valid),
        .det_item        (det_item),
        .cfg             (cfg),
        .out_valid       (m_valid),
        .out_average     (m_front_average),
        .out_approaching (m_approaching),
        .out_beeper      (m_beeper_on),
        .out_percent     (m_bar_percent)
    );

`ifndef NO_ASSERTIONS
    a_bar_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_bar_percent <= PCT_W'(PCT_MAX)))
        else $error("bar percent above full scale");

    a_bar_empty_below_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (CMP_W'(m_front_average) <= CMP_W'(cfg.front_low_limit)))
            |-> (m_bar_percent == '0))
        else $error("bar not empty at or below low limit");

    a_approach_needs_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_approaching)
            |-> (CMP_W'(m_front_average) > CMP_W'(cfg.approach_margin)))
        else $error("approach flagged without average above margin");
`endif

endmodule

[tb/parking_assist_proximity_test.sv]
`timescale 1ns / 1ps

module parking_assist_proximity_test;
    import pap_pkg::*;

    localparam int COUNT_CEILING   = 1023;
    localparam int BATTERY_EMPTY   = 3102;
    localparam int BATTERY_FULL    = 3723;
    localparam longint BATTERY_SLOPE   = 10562;
    localparam longint BATTERY_BIAS    = 32768000;
    localparam longint PROXIMITY_SLOPE = 2163;
    localparam longint PROXIMITY_BIAS  = 2011300;
    localparam int QUIET_LIMIT     = 2000;
    localparam int PHASES          = 10;
    localparam int PHASE_ITEMS     = 55;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] front;
        logic [BAT_W-1:0]       battery;
        logic                   near_zone;
        logic                   far_zone;
        logic                   horn;
    } tick_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] average;
        logic                   approaching;
        logic                   beeper;
        logic [PCT_W-1:0]       bar;
    } reading_t;

    class proximity_tracker;
        cfg_t                   settings;
        logic [SAMPLE_BITS-1:0] ring [WINDOW_LENGTH];
        int                     ring_slot;
        logic [TIMER_W-1:0]     store_count;
        logic [TIMER_W-1:0]     check_count;
        logic [TIMER_W-1:0]     beep_count;
        logic [SAMPLE_BITS-1:0] last_checked;
        logic                   beeper;
        reading_t               due [$];
        int                     errors;

        function new();
            settings.sample_interval   = RST_SAMPLE_INTERVAL;
            settings.approach_interval = RST_APPROACH_INTERVAL;
            settings.approach_margin   = RST_APPROACH_MARGIN;
            settings.near_half_period  = RST_NEAR_HALF_PERIOD;
            settings.far_half_period   = RST_FAR_HALF_PERIOD;
            settings.front_low_limit   = RST_FRONT_LOW_LIMIT;
            settings.front_high_limit  = RST_FRONT_HIGH_LIMIT;
            foreach (ring[i]) ring[i] = '0;
            ring_slot    = 0;
            store_count  = '0;
            check_count  = '0;
            beep_count   = '0;
            last_checked = '0;
            beeper       = 1'b0;
            errors       = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_SAMPLE_INTERVAL:   settings.sample_interval   = value[TIMER_W-1:0];
                REG_APPROACH_INTERVAL: settings.approach_interval = value[TIMER_W-1:0];
                REG_APPROACH_MARGIN:   settings.approach_margin   = value;
                REG_NEAR_HALF_PERIOD:  settings.near_half_period  = value[TIMER_W-1:0];
                REG_FAR_HALF_PERIOD:   settings.far_half_period   = value[TIMER_W-1:0];
                REG_FRONT_LOW_LIMIT:   settings.front_low_limit   = value;
                REG_FRONT_HIGH_LIMIT:  settings.front_high_limit  = value;
                default: ;
            endcase
        endfunction

        // Count up, saturating; fire and restart once the interval is reached
        function bit timer_fires(inout logic [TIMER_W-1:0] count,
                                 input logic [TIMER_W-1:0] interval);
            if (int'(count) < COUNT_CEILING) count = count + 1'b1;
            if (count >= interval) begin
                count = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function int bar_for(int mean, int battery);
            longint scaled;
            if (mean <= int'(settings.front_low_limit)) return 0;
            if (mean > int'(settings.front_high_limit)) begin
                if (battery <= BATTERY_EMPTY) return 0;
                if (battery >= BATTERY_FULL) return 100;
                scaled = BATTERY_SLOPE * battery - BATTERY_BIAS;
            end else begin
                scaled = PROXIMITY_SLOPE * mean - PROXIMITY_BIAS;
            end
            if (scaled < 0) return 0;
            scaled = scaled >>> 16;
            return (scaled > 100) ? 100 : int'(scaled);
        endfunction

        function void note_tick(tick_t t);
            reading_t         r;
            int               total;
            int               mean;
            logic             approach;
            logic [TIMER_W-1:0] half;
            total    = 0;
            approach = 1'b0;
            if (timer_fires(store_count, settings.sample_interval)) begin
                ring[ring_slot] = t.front;
                ring_slot = (ring_slot == WINDOW_LENGTH - 1) ? 0 : ring_slot + 1;
            end
            foreach (ring[i]) total += int'(ring[i]);
            mean = total / WINDOW_LENGTH;
            if (timer_fires(check_count, settings.approach_interval)) begin
                approach = (mean > int'(last_checked) + int'(settings.approach_margin));
                last_checked = SAMPLE_BITS'(mean);
            end
            if (t.horn) begin
                // horn holds the beeper on; its timer keeps counting but never fires
                if (int'(beep_count) < COUNT_CEILING) beep_count = beep_count + 1'b1;
                beeper = 1'b1;
            end else begin
                half = t.near_zone ? settings.near_half_period : settings.far_half_period;
                if (timer_fires(beep_count, half)) begin
                    if (!t.far_zone || (mean >= int'(settings.front_low_limit) && approach))
                        beeper = ~beeper;
                    else
                        beeper = 1'b0;
                end
            end
            r.average     = SAMPLE_BITS'(mean);
            r.approaching = approach;
            r.beeper      = beeper;
            r.bar         = PCT_W'(bar_for(mean, int'(t.battery)));
            due.push_back(r);
        endfunction

        function void check_result(reading_t got);
            reading_t want;
            if (due.size() == 0) begin
                $error("result item with no tick outstanding");
                errors++;
                return;
            end
            want = due.pop_front();
            if (got.average !== want.average) begin
                $error("front_average: expected %0d, actual %0d", want.average, got.average);
                errors++;
            end
            if (got.approaching !== want.approaching) begin
                $error("approaching: expected %0d, actual %0d",
                       want.approaching, got.approaching);
                errors++;
            end
            if (got.beeper !== want.beeper) begin
                $error("beeper_on: expected %0d, actual %0d", want.beeper, got.beeper);
                errors++;
            end
            if (got.bar !== want.bar) begin
                $error("bar_percent: expected %0d, actual %0d", want.bar, got.bar);
                errors++;
            end
        endfunction

        function int pending_count();
            return due.size();
        endfunction
    endclass

    logic                   aclk             = 1'b0;
    logic                   aresetn          = 1'b0;
    logic                   cfg_write        = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index        = '0;
    logic [CFG_W-1:0]       cfg_wdata        = '0;
    logic                   s_valid          = 1'b0;
    logic                   s_ready;
    logic [SAMPLE_BITS-1:0] s_front_sample   = '0;
    logic [BAT_W-1:0]       s_battery_sample = '0;
    logic                   s_near_zone      = 1'b0;
    logic                   s_far_zone       = 1'b0;
    logic                   s_horn_pressed   = 1'b0;
    logic                   m_valid;
    logic                   m_ready          = 1'b0;
    logic [SAMPLE_BITS-1:0] m_front_average;
    logic                   m_approaching;
    logic                   m_beeper_on;
    logic [PCT_W-1:0]       m_bar_percent;

    proximity_tracker sb;
    int drift_level;
    logic rear_near;
    logic rear_far;
    logic horn_held;
    int quiet_cycles = 0;
    int stall_left   = 0;
    int calm_left    = 0;

    parking_assist_proximity i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_front_sample   (s_front_sample),
        .s_battery_sample (s_battery_sample),
        .s_near_zone      (s_near_zone),
        .s_far_zone       (s_far_zone),
        .s_horn_pressed   (s_horn_pressed),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_front_average  (m_front_average),
        .m_approaching    (m_approaching),
        .m_beeper_on      (m_beeper_on),
        .m_bar_percent    (m_bar_percent)
    );

    always #2 aclk = ~aclk;

    // Receiver: short stalls mostly, the odd long one, and calm stretches
    always @(posedge aclk) begin
        int pick;
        logic take;
        take = 1'b1;
        if (stall_left > 0) begin
            stall_left--;
            take = 1'b0;
        end else if (calm_left > 0) begin
            calm_left--;
        end else begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                calm_left = $urandom_range(20, 80);
            end else if (pick < 25) begin
                stall_left = $urandom_range(0, 2);
                take = 1'b0;
            end else if (pick < 28) begin
                stall_left = $urandom_range(15, 40);
                take = 1'b0;
            end
        end
        m_ready <= take;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_front_average, m_approaching, m_beeper_on, m_bar_percent});
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic tick_t make_tick(int front, int battery, logic near_zone,
                                        logic far_zone, logic horn);
        tick_t t;
        t.front     = SAMPLE_BITS'(front);
        t.battery   = BAT_W'(battery);
        t.near_zone = near_zone;
        t.far_zone  = far_zone;
        t.horn      = horn;
        return t;
    endfunction

    // Mostly a drifting, rising front reading with random content; some noise and extremes
    function automatic tick_t next_tick();
        int pick;
        int front;
        int battery;
        pick = $urandom_range(99);
        if (pick < 8) begin
            front = $urandom_range(4095);
        end else if (pick < 12) begin
            front = pick[0] ? 4095 : 0;
        end else begin
            drift_level += int'($urandom_range(60)) - 20;
            if (drift_level > 4095 || drift_level < 0) drift_level = $urandom_range(1500);
            front = drift_level + int'($urandom_range(40)) - 20;
            if (front < 0) front = 0;
            if (front > 4095) front = 4095;
        end
        battery = ($urandom_range(9) < 7) ? $urandom_range(3050, 3780) : $urandom_range(4095);
        if ($urandom_range(19) == 0) rear_near = ~rear_near;
        if ($urandom_range(19) == 0) rear_far = ~rear_far;
        if ($urandom_range(32) == 0) horn_held = ~horn_held;
        return make_tick(front, battery, rear_near, rear_far, horn_held);
    endfunction

    function automatic cfg_t random_settings();
        cfg_t s;
        s.sample_interval = ($urandom_range(9) == 0) ? TIMER_W'($urandom_range(1, 1023))
                                                     : TIMER_W'($urandom_range(1, 6));
        s.approach_interval = ($urandom_range(9) == 0) ? TIMER_W'($urandom_range(1, 200))
                                                       : TIMER_W'($urandom_range(1, 12));
        s.approach_margin = ($urandom_range(4) == 0) ? CFG_W'($urandom_range(4095))
                                                     : CFG_W'($urandom_range(60));
        s.near_half_period = TIMER_W'($urandom_range(1, 20));
        s.far_half_period  = TIMER_W'($urandom_range(1, 40));
        s.front_low_limit  = CFG_W'($urandom_range(3000));
        // now and then leave the limits crossed
        s.front_high_limit = ($urandom_range(9) < 7)
                           ? CFG_W'($urandom_range(int'(s.front_low_limit), 4095))
                           : CFG_W'($urandom_range(4095));
        return s;
    endfunction

    function automatic cfg_t phase_settings(int p);
        cfg_t s;
        case (p)
            0: s = '{TIMER_W'(1), TIMER_W'(1), CFG_W'(0), TIMER_W'(1), TIMER_W'(1),
                     CFG_W'(0), CFG_W'(0)};
            1: s = '{TIMER_W'(1023), TIMER_W'(1023), CFG_W'(4095), TIMER_W'(1023),
                     TIMER_W'(1023), CFG_W'(4095), CFG_W'(4095)};
            // zero intervals fire on every tick
            2: s = '{TIMER_W'(0), TIMER_W'(0), CFG_W'(0), TIMER_W'(0), TIMER_W'(0),
                     CFG_W'(0), CFG_W'(4095)};
            3: s = '{RST_SAMPLE_INTERVAL, RST_APPROACH_INTERVAL, RST_APPROACH_MARGIN,
                     RST_NEAR_HALF_PERIOD, RST_FAR_HALF_PERIOD, RST_FRONT_LOW_LIMIT,
                     RST_FRONT_HIGH_LIMIT};
            default: s = random_settings();
        endcase
        return s;
    endfunction

    task automatic offer_tick(input tick_t t);
        s_valid          <= 1'b1;
        s_front_sample   <= t.front;
        s_battery_sample <= t.battery;
        s_near_zone      <= t.near_zone;
        s_far_zone       <= t.far_zone;
        s_horn_pressed   <= t.horn;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_tick(t);
    endtask

    // Idle the sender after an item; the first items of a phase go back to back
    task automatic pace(input int n);
        int pick;
        int gap;
        pick = $urandom_range(99);
        gap  = 0;
        if (n >= 15) begin
            if (pick >= 90)      gap = $urandom_range(8, 40);
            else if (pick >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Hold off the sender until every outstanding result has come back
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge aclk);
    endtask

    task automatic put_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.write_reg(idx, value);
    endtask

    task automatic apply_settings(input cfg_t s);
        put_reg(REG_SAMPLE_INTERVAL,   CFG_W'(s.sample_interval));
        put_reg(REG_APPROACH_INTERVAL, CFG_W'(s.approach_interval));
        put_reg(REG_APPROACH_MARGIN,   s.approach_margin);
        put_reg(REG_NEAR_HALF_PERIOD,  CFG_W'(s.near_half_period));
        put_reg(REG_FAR_HALF_PERIOD,   CFG_W'(s.far_half_period));
        put_reg(REG_FRONT_LOW_LIMIT,   s.front_low_limit);
        put_reg(REG_FRONT_HIGH_LIMIT,  s.front_high_limit);
        cfg_write <= 1'b0;
    endtask

    initial begin
        int battery_points [10];
        battery_points = '{0, 3102, 3103, 3500, 3722, 3723, 4095, 3200, 3600, 2000};
        sb = new();
        rear_near = 1'b0;
        rear_far  = 1'b1;
        horn_held = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Register defaults: field extremes, horn and rear zone combinations
        offer_tick(make_tick(4095, 4095, 1'b1, 1'b1, 1'b1));
        offer_tick(make_tick(0, 0, 1'b0, 1'b0, 1'b0));
        offer_tick(make_tick(4095, 3102, 1'b1, 1'b0, 1'b0));
        offer_tick(make_tick(0, 3723, 1'b0, 1'b1, 1'b1));
        settle();

        // Fill the ring to full scale so the bar shows battery, then drain most of it again
        apply_settings('{TIMER_W'(1), TIMER_W'(1), CFG_W'(0), TIMER_W'(1), TIMER_W'(2),
                         CFG_W'(100), CFG_W'(2000)});
        for (int i = 0; i < 10; i++)
            offer_tick(make_tick(4095, battery_points[i], i[0], i[1], i == 5));
        for (int i = 0; i < 8; i++)
            offer_tick(make_tick(0, 3400, i[0], 1'b1, 1'b0));

        for (int p = 0; p < PHASES; p++) begin
            settle();
            apply_settings(phase_settings(p));
            drift_level = $urandom_range(2000);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                offer_tick(next_tick());
                if (n == 30)
                    settle();
                else
                    pace(n);
            end
        end

        settle();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_count() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
